// ===== hdl/sorted_array_priority_queue_macros.svh =====
// Assertion macros for the sorted-array priority queue.
// Used by the top level only; they expect signals named clk and rst_n in scope.
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_MACROS_SVH

`ifndef ASSERT_OFF
`define SAPQ_ASSERT_HOLD(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sapq: invariant violated");
`define SAPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sapq: sequence violated");
`define SAPQ_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sapq: implication violated");
`else
`define SAPQ_ASSERT_HOLD(label, cond)
`define SAPQ_ASSERT_NEXT(label, ante, cons)
`define SAPQ_ASSERT_IMPL(label, ante, cons)
`endif

`endif

// ===== hdl/sapq_pkg.sv =====
// Shared types and constants for the sorted-array priority queue.
// No dependencies; imported by the cell and the top level.
package sapq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;
    localparam int VALUE_W             = 32;
    localparam int STATUS_W            = 2;

    typedef enum logic
    {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } command_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_ENQ   = 2'd0,
        ST_FULL  = 2'd1,
        ST_DEQ   = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // Per-cell position flags, decoded from head and tail by the top level.
    typedef struct packed
    {
        logic live;     // cell holds a queued entry
        logic in_range; // cell may take part in an insert (head .. tail+1)
        logic first;    // cell is the head slot
        logic last;     // cell is the slot just above the tail
    } cell_ctl_t;

endpackage

// ===== hdl/sapq_cell.sv =====
// One slot of the sorted array: holds an entry, compares it with the
// incoming value and passes its entry to the next cell up on an insert. Uses sapq_pkg.
module sapq_cell
(
    input  logic                                clk,
    input  sapq_pkg::cell_ctl_t                 ctl,
    input  logic                                write_en,
    input  logic signed [sapq_pkg::VALUE_W-1:0] value,
    input  logic signed [sapq_pkg::VALUE_W-1:0] left_slot,
    input  logic                                left_gt,
    output logic signed [sapq_pkg::VALUE_W-1:0] slot,
    output logic                                gt
);
    import sapq_pkg::*;

    logic signed [VALUE_W-1:0] slot_reg;
    logic signed [VALUE_W-1:0] slot_next;
    logic                      take_value;

    // The live entries are sorted, so gt is set on a contiguous run up to the tail.
    assign gt = ctl.live & (value < slot_reg);

    // The new item lands at the lowest slot of the run, or just above the tail.
    assign take_value = ctl.in_range & (ctl.first | ~left_gt) & (ctl.last | gt);

    always_comb
    begin
        priority if (left_gt)
        begin
            slot_next = left_slot;
        end
        else if (take_value)
        begin
            slot_next = value;
        end
        else
        begin
            slot_next = slot_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            slot_reg <= slot_next;
        end
    end

    assign slot = slot_reg;

endmodule

// ===== hdl/sorted_array_priority_queue.sv =====
// Top level of the sorted-array priority queue: head/tail control and the cell row.
// Depends on sapq_pkg, sapq_cell and sorted_array_priority_queue_macros.svh.
//
//   channel   handshake        payload
//   command   start / busy     command, value
//   result    done (strobe)    status, out_value
//
// Every item is completed at its accepting edge: an insert updates all cells in
// parallel, where the critical path is one 32-bit compare per cell and the select
// against its neighbour. The result strobe follows in the next cycle.
// busy is never raised, so an item may be given in every cycle, and the receiver
// cannot stall. Reset empties the queue: head and tail go to zero and the empty
// flag is set; slot contents stay undefined until written.
`include "sorted_array_priority_queue_macros.svh"

module sorted_array_priority_queue
#(
    parameter int QUEUE_DEPTH = sapq_pkg::DEFAULT_QUEUE_DEPTH
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 command,
    input  logic signed [sapq_pkg::VALUE_W-1:0]  value,
    output logic                                 done,
    output logic        [sapq_pkg::STATUS_W-1:0] status,
    output logic signed [sapq_pkg::VALUE_W-1:0]  out_value
);
    import sapq_pkg::*;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic [IDX_W-1:0]          head_reg, head_next;
    logic [IDX_W-1:0]          tail_reg, tail_next;
    logic                      empty_reg, empty_next;
    logic                      done_reg;
    status_t                   status_reg, status_next;
    logic signed [VALUE_W-1:0] out_value_reg, out_value_next;

    logic                      accept;
    logic                      full;
    logic                      cell_we;
    logic [IDX_W:0]            tail_plus;
    logic signed [VALUE_W-1:0] head_entry;

    cell_ctl_t                 ctl     [QUEUE_DEPTH];
    logic signed [VALUE_W-1:0] slots   [QUEUE_DEPTH];
    logic                      gts     [QUEUE_DEPTH];
    logic signed [VALUE_W-1:0] gated   [QUEUE_DEPTH];

    assign busy      = 1'b0;
    assign accept    = start & ~busy;
    assign full      = ~empty_reg & (tail_reg == IDX_W'(QUEUE_DEPTH - 1));
    assign tail_plus = {1'b0, tail_reg} + (IDX_W+1)'(1);
    assign cell_we   = accept & (command == CMD_ENQ) & ~full;

    // Position flags for each cell. While empty, head and tail sit at slot zero.
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cells
            logic head_le, le_tail, le_tail_plus;

            assign head_le      = head_reg <= IDX_W'(gi);
            assign le_tail      = IDX_W'(gi) <= tail_reg;
            assign le_tail_plus = (IDX_W+1)'(gi) <= tail_plus;

            assign ctl[gi].live     = ~empty_reg & head_le & le_tail;
            assign ctl[gi].first    = head_reg == IDX_W'(gi);
            assign ctl[gi].last     = empty_reg ? (gi == 0)
                                                : ((IDX_W+1)'(gi) == tail_plus);
            assign ctl[gi].in_range = empty_reg ? (gi == 0)
                                                : (head_le & le_tail_plus);

            assign gated[gi] = ctl[gi].first ? slots[gi] : '0;

            if (gi == 0)
            begin : g_bottom
                sapq_cell u_cell
                (
                    .clk       (clk),
                    .ctl       (ctl[gi]),
                    .write_en  (cell_we),
                    .value     (value),
                    .left_slot ('0),
                    .left_gt   (1'b0),
                    .slot      (slots[gi]),
                    .gt        (gts[gi])
                );
            end
            else
            begin : g_upper
                sapq_cell u_cell
                (
                    .clk       (clk),
                    .ctl       (ctl[gi]),
                    .write_en  (cell_we),
                    .value     (value),
                    .left_slot (slots[gi-1]),
                    .left_gt   (gts[gi-1]),
                    .slot      (slots[gi]),
                    .gt        (gts[gi])
                );
            end
        end
    endgenerate

    // Only the head cell passes its entry, so an OR across the row selects it.
    always_comb
    begin
        head_entry = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            head_entry = head_entry | gated[i];
        end
    end

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        empty_next     = empty_reg;
        status_next    = status_reg;
        out_value_next = '0;
        if (accept)
        begin
            unique case (command_t'(command))
                CMD_ENQ:
                begin
                    priority if (empty_reg)
                    begin
                        head_next   = '0;
                        tail_next   = '0;
                        empty_next  = 1'b0;
                        status_next = ST_ENQ;
                    end
                    else if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        tail_next   = tail_plus[IDX_W-1:0];
                        status_next = ST_ENQ;
                    end
                end
                CMD_DEQ:
                begin
                    priority if (empty_reg)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else if (head_reg == tail_reg)
                    begin
                        head_next      = '0;
                        tail_next      = '0;
                        empty_next     = 1'b1;
                        status_next    = ST_DEQ;
                        out_value_next = head_entry;
                    end
                    else
                    begin
                        head_next      = head_reg + IDX_W'(1);
                        status_next    = ST_DEQ;
                        out_value_next = head_entry;
                    end
                end
                default:
                begin
                    status_next = ST_EMPTY;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            out_value_reg <= out_value_next;
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign out_value = out_value_reg;

    `SAPQ_ASSERT_NEXT(a_one_result_per_item, accept, done)
    `SAPQ_ASSERT_HOLD(a_empty_resets_indices, !empty_reg || (head_reg == '0 && tail_reg == '0))
    `SAPQ_ASSERT_HOLD(a_head_not_past_tail, head_reg <= tail_reg)
    `SAPQ_ASSERT_IMPL(a_value_only_on_dequeue, done && status != ST_DEQ, out_value == '0)

endmodule
